// ===== rtl/ivs_pkg.sv =====
package ivs_pkg;

   localparam int NUM_TANKS = 3;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_PAUSE = 2'd0;
   localparam phase_type PH_PRE   = 2'd1;
   localparam phase_type PH_WATER = 2'd2;

   // batch position that stands for the shared pause
   localparam logic [1:0] BPOS_SHARED = 2'd3;

   localparam logic [31:0] MS_PER_MIN = 32'd60000;
   localparam logic [31:0] MS_PER_S   = 32'd1000;
   localparam logic [31:0] STAGGER_MS = 32'd30000;

   // drive word bit positions
   localparam int DRV_RET  = 3;
   localparam int DRV_FEED = 4;
   localparam int DRV_CIRC = 5;

   // register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 33;
   localparam logic [CSR_IDX_W-1:0] REG_TANK0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TANK1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TANK2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PREFLUSH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BATCH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CIRC     = 3'd5;

   typedef struct packed {
      logic [NUM_TANKS-1:0][32:0] tank_times;
      logic [8:0]                 preflush;
      logic                       batch_mode;
      logic [16:0]                circulation;
   } cfg_type;

   typedef struct packed {
      logic [31:0]                now_ms;
      phase_type [NUM_TANKS-1:0]  phase;
      logic [NUM_TANKS-1:0][31:0] tstart;
      logic [1:0]                 bpos;
      logic                       bpre;
      logic [31:0]                bpause_start;
      logic                       circ_run;
      logic [31:0]                circ_start;
      logic [5:0]                 drv;
   } state_type;

   function automatic logic [31:0] secs_to_ms(input logic [7:0] s);
      return 32'(s) * MS_PER_S;
   endfunction

   function automatic logic [31:0] mins_to_ms(input logic [7:0] m);
      return 32'(m) * MS_PER_MIN;
   endfunction

   function automatic logic [31:0] open_ms(input logic [32:0] t, input logic light);
      return secs_to_ms(light ? t[7:0] : t[23:16]);
   endfunction

   function automatic logic [31:0] rest_ms(input logic [32:0] t, input logic light);
      return mins_to_ms(light ? t[15:8] : t[31:24]);
   endfunction

   // state after reset: staggered tank timers, batch in the shared pause
   function automatic state_type reset_state();
      state_type s;
      s      = '0;
      s.bpos = BPOS_SHARED;
      for (int i = 0; i < NUM_TANKS; i++) begin
         s.tstart[i] = 32'd0 - 32'(i) * STAGGER_MS;
      end
      return s;
   endfunction

endpackage

// ===== rtl/ivs_if.sv =====
interface ivs_req_if;
   logic valid;
   logic ready;
   logic command;
   logic light_on;

   modport source (output valid, command, light_on, input ready);
   modport sink (input valid, command, light_on, output ready);
endinterface

interface ivs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] tank_valves;
   logic       return_valve;
   logic       feed_pump;
   logic       circulation_pump;
   logic [5:0] tank_phases;

   modport source (output valid, tank_valves, return_valve, feed_pump, circulation_pump,
                   tank_phases, input ready);
   modport sink (input valid, tank_valves, return_valve, feed_pump, circulation_pump,
                 tank_phases, output ready);
endinterface

interface ivs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [32:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ivs_step.sv =====
module ivs_step
   import ivs_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  logic      command,
   input  logic      light_on,
   output state_type nxt
);

   always_comb begin : step_logic
      state_type   n;
      logic        ret;
      logic        busy;
      logic        found;
      logic [1:0]  first;
      logic [31:0] el;
      logic        pre_on;
      logic [31:0] pre_ms;
      logic        any_w;
      logic        any_e;
      logic [32:0] pos_times;

      n         = cur;
      ret       = 1'b0;
      busy      = 1'b0;
      found     = 1'b0;
      first     = '0;
      el        = '0;
      any_w     = 1'b0;
      any_e     = 1'b0;
      pos_times = '0;
      pre_on    = cfg.preflush[8] && (cfg.preflush[7:0] != 8'd0);
      pre_ms    = secs_to_ms(cfg.preflush[7:0]);

      if (command) begin
         // runtime reset: pumps and circulation cycle are left alone
         for (int i = 0; i < NUM_TANKS; i++) begin
            n.drv[i]    = 1'b0;
            n.phase[i]  = PH_PAUSE;
            n.tstart[i] = cur.now_ms;
         end
         n.drv[DRV_RET]  = 1'b0;
         n.bpos          = BPOS_SHARED;
         n.bpre          = 1'b0;
         n.bpause_start  = cur.now_ms;
      end else begin
         n.now_ms = cur.now_ms + 32'd1;

         if (!cfg.batch_mode) begin
            // independent timers, tanks visited in order so later ones see
            // the phases earlier ones just took
            for (int i = 0; i < NUM_TANKS; i++) begin
               if (!cfg.tank_times[i][32]) begin
                  n.drv[i] = 1'b0;
               end else begin
                  el = n.now_ms - n.tstart[i];
                  case (n.phase[i])
                     PH_PAUSE: begin
                        if (el >= rest_ms(cfg.tank_times[i], light_on)) begin
                           busy = 1'b0;
                           for (int j = 0; j < NUM_TANKS; j++) begin
                              if (j != i && cfg.tank_times[j][32] &&
                                  (n.phase[j] == PH_PRE || n.phase[j] == PH_WATER))
                                 busy = 1'b1;
                           end
                           if (!busy) begin
                              n.tstart[i] = n.now_ms;
                              if (pre_on) begin
                                 n.phase[i] = PH_PRE;
                              end else begin
                                 n.phase[i] = PH_WATER;
                                 n.drv[i]   = 1'b1;
                              end
                           end
                        end
                     end
                     PH_PRE: begin
                        ret = 1'b1;
                        if (el >= pre_ms) begin
                           n.phase[i]  = PH_WATER;
                           n.tstart[i] = n.now_ms;
                           n.drv[i]    = 1'b1;
                        end
                     end
                     PH_WATER: begin
                        if (el >= open_ms(cfg.tank_times[i], light_on)) begin
                           n.drv[i]    = 1'b0;
                           n.phase[i]  = PH_PAUSE;
                           n.tstart[i] = n.now_ms;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            n.drv[DRV_RET] = ret;
         end else begin
            for (int i = 0; i < NUM_TANKS; i++) begin
               if (2'(i) != cur.bpos) n.drv[i] = 1'b0;
            end

            if (cur.bpos >= 2'(NUM_TANKS)) begin
               // shared pause timed from tank 0
               for (int i = 0; i < NUM_TANKS; i++) begin
                  n.phase[i]  = PH_PAUSE;
                  n.tstart[i] = cur.bpause_start;
               end
               n.drv[DRV_RET] = 1'b0;
               if (n.now_ms - cur.bpause_start >= rest_ms(cfg.tank_times[0], light_on)) begin
                  for (int i = 0; i < NUM_TANKS; i++) begin
                     if (!found && cfg.tank_times[i][32]) begin
                        found = 1'b1;
                        first = 2'(i);
                     end
                  end
                  if (!found) begin
                     n.bpause_start = n.now_ms;
                  end else begin
                     n.bpos = first;
                     for (int i = 0; i < NUM_TANKS; i++) begin
                        if (2'(i) == first) begin
                           n.tstart[i] = n.now_ms;
                           if (pre_on) begin
                              n.phase[i] = PH_PRE;
                           end else begin
                              n.phase[i] = PH_WATER;
                              n.drv[i]   = 1'b1;
                           end
                        end
                     end
                     n.bpre = pre_on;
                  end
               end
            end else begin
               for (int i = 0; i < NUM_TANKS; i++) begin
                  if (2'(i) == cur.bpos) begin
                     el        = n.now_ms - cur.tstart[i];
                     pos_times = cfg.tank_times[i];
                  end
               end
               if (cur.bpre) begin
                  n.drv[DRV_RET] = 1'b1;
                  if (el >= pre_ms) begin
                     n.bpre = 1'b0;
                     for (int i = 0; i < NUM_TANKS; i++) begin
                        if (2'(i) == cur.bpos) begin
                           n.phase[i]  = PH_WATER;
                           n.tstart[i] = n.now_ms;
                           n.drv[i]    = 1'b1;
                        end
                     end
                  end
               end else begin
                  n.drv[DRV_RET] = 1'b0;
                  if (el >= open_ms(pos_times, light_on)) begin
                     // hand over to the next enabled tank, or back to the pause
                     for (int i = 0; i < NUM_TANKS; i++) begin
                        if (2'(i) == cur.bpos) n.drv[i] = 1'b0;
                        if (!found && 2'(i) > cur.bpos && cfg.tank_times[i][32]) begin
                           found = 1'b1;
                           first = 2'(i);
                        end
                     end
                     if (!found) begin
                        n.bpos         = BPOS_SHARED;
                        n.bpause_start = n.now_ms;
                     end else begin
                        n.bpos = first;
                        for (int i = 0; i < NUM_TANKS; i++) begin
                           if (2'(i) == first) begin
                              n.phase[i]  = PH_WATER;
                              n.tstart[i] = n.now_ms;
                              n.drv[i]    = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end

         for (int i = 0; i < NUM_TANKS; i++) begin
            if (cfg.tank_times[i][32]) begin
               any_e = 1'b1;
               if (n.phase[i] == PH_WATER) any_w = 1'b1;
            end
         end
         n.drv[DRV_FEED] = any_w;

         // circulation pump run/pause cycle
         if (!cfg.circulation[16] || !any_e) begin
            n.drv[DRV_CIRC] = 1'b0;
            n.circ_run      = 1'b0;
            n.circ_start    = n.now_ms;
         end else if (!cur.circ_run) begin
            if (n.now_ms - cur.circ_start >= mins_to_ms(cfg.circulation[15:8])) begin
               n.circ_run      = 1'b1;
               n.circ_start    = n.now_ms;
               n.drv[DRV_CIRC] = 1'b1;
            end
         end else if (n.now_ms - cur.circ_start >= secs_to_ms(cfg.circulation[7:0])) begin
            n.circ_run      = 1'b0;
            n.circ_start    = n.now_ms;
            n.drv[DRV_CIRC] = 1'b0;
         end
      end

      nxt = n;
   end

endmodule

// ===== rtl/irrigation_valve_sequencer.sv =====
// a request is held in the request register, its result in the response register
// throughput: one request per cycle, the request register and the response
//    register stall together only while a response waits to be taken
// reset (synchronous, active high): control, state and configuration registers
//    cleared, tank timers staggered by thirty seconds, batch in the shared pause,
//    all drives off
module irrigation_valve_sequencer
   import ivs_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ivs_req_if.sink   req_if,
   ivs_rsp_if.source rsp_if,
   ivs_csr_if.sink   csr_if
);

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // request register
   logic in_vld_ff, in_vld_in;
   logic in_cmd_ff, in_cmd_in;
   logic in_light_ff, in_light_in;

   // sequencing state
   state_type st_ff;
   state_type st_in;
   state_type st_step;

   // response register
   logic       rsp_vld_ff, rsp_vld_in;
   logic [2:0] rsp_valves_ff, rsp_valves_in;
   logic       rsp_ret_ff, rsp_ret_in;
   logic       rsp_feed_ff, rsp_feed_in;
   logic       rsp_circ_ff, rsp_circ_in;
   logic [5:0] rsp_phases_ff, rsp_phases_in;

   logic advance;
   logic req_take;

   // the held request moves on whenever the response slot is free or emptying
   assign advance  = in_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;
   assign req_take = req_if.valid && req_if.ready;

   // configuration port never stalls
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_TANK0:    cfg_in.tank_times[0] = csr_if.data;
            REG_TANK1:    cfg_in.tank_times[1] = csr_if.data;
            REG_TANK2:    cfg_in.tank_times[2] = csr_if.data;
            REG_PREFLUSH: cfg_in.preflush      = csr_if.data[8:0];
            REG_BATCH:    cfg_in.batch_mode    = csr_if.data[0];
            REG_CIRC:     cfg_in.circulation   = csr_if.data[16:0];
            default: ;    // unmapped indexes are dropped
         endcase
      end
   end

   // request register loads on take, empties once it has been evaluated
   always_comb begin
      in_vld_in   = in_vld_ff;
      in_cmd_in   = in_cmd_ff;
      in_light_in = in_light_ff;
      if (req_take) begin
         in_vld_in   = 1'b1;
         in_cmd_in   = req_if.command;
         in_light_in = req_if.light_on;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   // one tick or runtime reset evaluated in a single pass
   ivs_step u_step (
      .cfg      (cfg_ff),
      .cur      (st_ff),
      .command  (in_cmd_ff),
      .light_on (in_light_ff),
      .nxt      (st_step)
   );

   assign st_in = advance ? st_step : st_ff;

   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_valves_in = rsp_valves_ff;
      rsp_ret_in    = rsp_ret_ff;
      rsp_feed_in   = rsp_feed_ff;
      rsp_circ_in   = rsp_circ_ff;
      rsp_phases_in = rsp_phases_ff;
      if (advance) begin
         rsp_vld_in    = 1'b1;
         rsp_valves_in = st_step.drv[2:0];
         rsp_ret_in    = st_step.drv[DRV_RET];
         rsp_feed_in   = st_step.drv[DRV_FEED];
         rsp_circ_in   = st_step.drv[DRV_CIRC];
         rsp_phases_in = 6'(st_step.phase);
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_vld_ff   <= 1'b0;
         in_cmd_ff   <= 1'b0;
         in_light_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         // tanks start staggered so they do not all open together
         st_ff       <= reset_state();
      end else begin
         cfg_ff      <= cfg_in;
         in_vld_ff   <= in_vld_in;
         in_cmd_ff   <= in_cmd_in;
         in_light_ff <= in_light_in;
         rsp_vld_ff  <= rsp_vld_in;
         st_ff       <= st_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_valves_ff <= rsp_valves_in;
      rsp_ret_ff    <= rsp_ret_in;
      rsp_feed_ff   <= rsp_feed_in;
      rsp_circ_ff   <= rsp_circ_in;
      rsp_phases_ff <= rsp_phases_in;
   end

   assign rsp_if.valid            = rsp_vld_ff;
   assign rsp_if.tank_valves      = rsp_valves_ff;
   assign rsp_if.return_valve     = rsp_ret_ff;
   assign rsp_if.feed_pump        = rsp_feed_ff;
   assign rsp_if.circulation_pump = rsp_circ_ff;
   assign rsp_if.tank_phases      = rsp_phases_ff;

`ifndef SYNTHESIS
   // a tick advances the millisecond clock by exactly one
   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      advance && !in_cmd_ff |=> st_ff.now_ms == $past(st_ff.now_ms) + 32'd1)
      else $error("millisecond clock did not advance on tick");

   // nothing held and nothing waiting means no response appears
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff && !rsp_vld_ff |=> !rsp_vld_ff)
      else $error("response without request");

   // while batch sits in the shared pause every valve is closed
   a_batch_pause: assert property (@(posedge clock) disable iff (reset)
      advance && cfg_ff.batch_mode |=> st_ff.bpos != BPOS_SHARED ||
      (st_ff.drv[2:0] == 3'b000 && !st_ff.drv[DRV_RET]))
      else $error("valve open during shared batch pause");
`endif

endmodule

// ===== tb/irrigation_valve_sequencer_test.sv =====
`timescale 1ns / 1ps

module irrigation_valve_sequencer_test
   import ivs_pkg::*;
();

   // pipeline depth of the block, used when letting it settle
   localparam int LATENCY     = 2;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_REQS = 2000;

   // request codes
   localparam logic CMD_TICK      = 1'b0;
   localparam logic CMD_RESET_RUN = 1'b1;

   typedef struct packed {
      logic [2:0] valves;
      logic       return_valve;
      logic       feed_pump;
      logic       circulation_pump;
      logic [5:0] phases;
   } drive_word_type;

   logic clock;
   logic reset;

   ivs_req_if req_if ();
   ivs_rsp_if rsp_if ();
   ivs_csr_if csr_if ();

   irrigation_valve_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // shadow copy of the register file
   logic [32:0] tank_times_cfg [NUM_TANKS];
   logic [8:0]  preflush_cfg;
   logic        batch_cfg;
   logic [16:0] circ_cfg;

   // shadow copy of the sequencing state
   logic [31:0] clock_ms;
   phase_type   tank_phase [NUM_TANKS];
   logic [31:0] tank_start [NUM_TANKS];
   logic [1:0]  batch_slot;
   logic        batch_flushing;
   logic [31:0] batch_rest_start;
   logic        circ_running;
   logic [31:0] circ_start;
   logic [5:0]  drive;

   // drive words still owed by the block, oldest first
   drive_word_type expected_drives [$];

   int fault_count;
   int cycle_count;
   bit idling_on;
   int rsp_hold_cycles;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // sequencer model
   // ---------------------------------------------------------------

   function automatic logic tank_enabled(int t);
      return tank_times_cfg[t][32];
   endfunction

   // open time of a tank in ms for the current light phase
   function automatic logic [31:0] watering_ms(int t, logic light);
      logic [7:0] secs;
      secs = light ? tank_times_cfg[t][7:0] : tank_times_cfg[t][23:16];
      return 32'(secs) * MS_PER_S;
   endfunction

   // pause time of a tank in ms for the current light phase
   function automatic logic [31:0] resting_ms(int t, logic light);
      logic [7:0] mins;
      mins = light ? tank_times_cfg[t][15:8] : tank_times_cfg[t][31:24];
      return 32'(mins) * MS_PER_MIN;
   endfunction

   // preflush counts only when enabled and non-zero
   function automatic logic flush_active();
      return preflush_cfg[8] && (preflush_cfg[7:0] != 8'd0);
   endfunction

   function automatic logic [31:0] flush_ms();
      return 32'(preflush_cfg[7:0]) * MS_PER_S;
   endfunction

   function automatic int first_enabled_from(int from);
      for (int t = from; t < NUM_TANKS; t++)
         if (tank_enabled(t)) return t;
      return -1;
   endfunction

   function automatic void clear_sequencer();
      for (int t = 0; t < NUM_TANKS; t++) begin
         tank_times_cfg[t] = '0;
         tank_phase[t]     = PH_PAUSE;
         // timers staggered by thirty seconds per tank
         tank_start[t]     = 32'd0 - 32'(t) * STAGGER_MS;
      end
      preflush_cfg     = '0;
      batch_cfg        = 1'b0;
      circ_cfg         = '0;
      clock_ms         = '0;
      batch_slot       = BPOS_SHARED;
      batch_flushing   = 1'b0;
      batch_rest_start = '0;
      circ_running     = 1'b0;
      circ_start       = '0;
      drive            = '0;
   endfunction

   // independent timers, a tank starts only if no other enabled one flushes or waters
   function automatic void step_independent(logic light);
      logic        flushing;
      logic        busy;
      logic [31:0] elapsed;
      flushing = 1'b0;
      for (int t = 0; t < NUM_TANKS; t++) begin
         if (!tank_enabled(t)) begin
            // phase is frozen, only the valve closes
            drive[t] = 1'b0;
         end else begin
            elapsed = clock_ms - tank_start[t];
            case (tank_phase[t])
               PH_PAUSE: begin
                  if (elapsed >= resting_ms(t, light)) begin
                     busy = 1'b0;
                     for (int o = 0; o < NUM_TANKS; o++)
                        if (o != t && tank_enabled(o) &&
                            (tank_phase[o] == PH_PRE || tank_phase[o] == PH_WATER))
                           busy = 1'b1;
                     if (!busy) begin
                        tank_start[t] = clock_ms;
                        if (flush_active()) begin
                           tank_phase[t] = PH_PRE;
                        end else begin
                           tank_phase[t] = PH_WATER;
                           drive[t]      = 1'b1;
                        end
                     end
                  end
               end
               PH_PRE: begin
                  flushing = 1'b1;
                  if (elapsed >= flush_ms()) begin
                     tank_phase[t] = PH_WATER;
                     tank_start[t] = clock_ms;
                     drive[t]      = 1'b1;
                  end
               end
               PH_WATER: begin
                  if (elapsed >= watering_ms(t, light)) begin
                     drive[t]      = 1'b0;
                     tank_phase[t] = PH_PAUSE;
                     tank_start[t] = clock_ms;
                  end
               end
               default: ;
            endcase
         end
      end
      drive[DRV_RET] = flushing;
   endfunction

   // shared pause from tank 0, then every enabled tank in turn
   function automatic void step_batch(logic light);
      int          slot;
      int          nxt;
      logic [31:0] elapsed;
      for (int t = 0; t < NUM_TANKS; t++)
         if (t != int'(batch_slot)) drive[t] = 1'b0;

      if (int'(batch_slot) >= NUM_TANKS) begin
         for (int t = 0; t < NUM_TANKS; t++) begin
            tank_phase[t] = PH_PAUSE;
            tank_start[t] = batch_rest_start;
         end
         drive[DRV_RET] = 1'b0;
         if (clock_ms - batch_rest_start >= resting_ms(0, light)) begin
            slot = first_enabled_from(0);
            if (slot < 0) begin
               // nothing to water, pause starts over
               batch_rest_start = clock_ms;
            end else begin
               batch_slot       = 2'(slot);
               tank_start[slot] = clock_ms;
               if (flush_active()) begin
                  batch_flushing   = 1'b1;
                  tank_phase[slot] = PH_PRE;
               end else begin
                  batch_flushing   = 1'b0;
                  tank_phase[slot] = PH_WATER;
                  drive[slot]      = 1'b1;
               end
            end
         end
      end else begin
         slot    = int'(batch_slot);
         elapsed = clock_ms - tank_start[slot];
         if (batch_flushing) begin
            drive[DRV_RET] = 1'b1;
            if (elapsed >= flush_ms()) begin
               batch_flushing   = 1'b0;
               tank_phase[slot] = PH_WATER;
               tank_start[slot] = clock_ms;
               drive[slot]      = 1'b1;
            end
         end else begin
            drive[DRV_RET] = 1'b0;
            // a tank disabled mid-turn still runs out its time
            if (elapsed >= watering_ms(slot, light)) begin
               drive[slot] = 1'b0;
               nxt = first_enabled_from(slot + 1);
               if (nxt < 0) begin
                  batch_slot       = BPOS_SHARED;
                  batch_rest_start = clock_ms;
               end else begin
                  batch_slot      = 2'(nxt);
                  tank_phase[nxt] = PH_WATER;
                  tank_start[nxt] = clock_ms;
                  drive[nxt]      = 1'b1;
               end
            end
         end
      end
   endfunction

   function automatic void step_circulation(logic any_enabled);
      if (!circ_cfg[16] || !any_enabled) begin
         drive[DRV_CIRC] = 1'b0;
         circ_running    = 1'b0;
         circ_start      = clock_ms;
      end else if (!circ_running) begin
         if (clock_ms - circ_start >= 32'(circ_cfg[15:8]) * MS_PER_MIN) begin
            circ_running    = 1'b1;
            circ_start      = clock_ms;
            drive[DRV_CIRC] = 1'b1;
         end
      end else if (clock_ms - circ_start >= 32'(circ_cfg[7:0]) * MS_PER_S) begin
         circ_running    = 1'b0;
         circ_start      = clock_ms;
         drive[DRV_CIRC] = 1'b0;
      end
   endfunction

   // advance the model by one request and return the drive word it gives
   function automatic drive_word_type predict_drives(logic cmd, logic light);
      drive_word_type word;
      logic           any_en;
      logic           any_water;
      if (cmd == CMD_RESET_RUN) begin
         // pumps and the circulation cycle are left alone
         for (int t = 0; t < NUM_TANKS; t++) begin
            drive[t]      = 1'b0;
            tank_phase[t] = PH_PAUSE;
            tank_start[t] = clock_ms;
         end
         drive[DRV_RET]   = 1'b0;
         batch_slot       = BPOS_SHARED;
         batch_flushing   = 1'b0;
         batch_rest_start = clock_ms;
      end else begin
         clock_ms = clock_ms + 32'd1;
         if (batch_cfg) step_batch(light);
         else step_independent(light);
         any_en    = 1'b0;
         any_water = 1'b0;
         for (int t = 0; t < NUM_TANKS; t++)
            if (tank_enabled(t)) begin
               any_en = 1'b1;
               if (tank_phase[t] == PH_WATER) any_water = 1'b1;
            end
         drive[DRV_FEED] = any_water;
         step_circulation(any_en);
      end
      word.valves           = drive[NUM_TANKS-1:0];
      word.return_valve     = drive[DRV_RET];
      word.feed_pump        = drive[DRV_FEED];
      word.circulation_pump = drive[DRV_CIRC];
      word.phases           = '0;
      for (int t = 0; t < NUM_TANKS; t++)
         word.phases[2*t +: 2] = tank_phase[t];
      return word;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_TANK0:    tank_times_cfg[0] = value;
         REG_TANK1:    tank_times_cfg[1] = value;
         REG_TANK2:    tank_times_cfg[2] = value;
         REG_PREFLUSH: preflush_cfg      = value[8:0];
         REG_BATCH:    batch_cfg         = value[0];
         REG_CIRC:     circ_cfg          = value[16:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // durations lean towards zero and one so the phases actually turn over
   function automatic logic [7:0] pick_duration(int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 8'd0;
      if (r < zero_pct + (100 - zero_pct) / 2) return 8'd1;
      if (r < 90) return 8'd2;
      if (r < 97) return 8'($urandom_range(3, 254));
      return 8'hFF;
   endfunction

   function automatic logic [32:0] tank_word(logic en, logic [7:0] open_light,
                                             logic [7:0] pause_light,
                                             logic [7:0] open_dark,
                                             logic [7:0] pause_dark);
      return {en, pause_dark, open_dark, pause_light, open_light};
   endfunction

   function automatic string drive_text(drive_word_type w);
      return $sformatf("valves=%b ret=%b feed=%b circ=%b phases=%b",
                       w.valves, w.return_valve, w.feed_pump,
                       w.circulation_pump, w.phases);
   endfunction

   // offer one request, hold it until taken, then predict its drive word
   task automatic send_request(input logic cmd, input logic light);
      int             gap;
      drive_word_type word;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.light_on <= light;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      word = predict_drives(cmd, light);
      expected_drives.push_back(word);
   endtask

   task automatic tick(input logic light);
      send_request(CMD_TICK, light);
   endtask

   // stop offering and let every owed response come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // registers are only touched with the block idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_register(idx, value);
      csr_if.valid <= 1'b0;
   endtask

   task automatic randomise_settings();
      logic [8:0]  flush;
      logic [16:0] circ;
      for (int t = 0; t < NUM_TANKS; t++)
         if ($urandom_range(0, 3) != 0)
            write_register(REG_TANK0 + 3'(t),
                           tank_word($urandom_range(0, 3) != 0, pick_duration(40),
                                     pick_duration(75), pick_duration(40),
                                     pick_duration(75)));
      flush = {1'($urandom_range(0, 1)), pick_duration(30)};
      circ  = {1'($urandom_range(0, 4) != 0), pick_duration(70), pick_duration(30)};
      if ($urandom_range(0, 3) != 0) write_register(REG_PREFLUSH, 33'(flush));
      if ($urandom_range(0, 3) != 0) write_register(REG_BATCH, 33'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) write_register(REG_CIRC, 33'(circ));
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // nothing enabled straight after reset: all drives stay off
   task automatic test_idle_after_reset();
      tick(1'b1);
      tick(1'b0);
      send_request(CMD_RESET_RUN, 1'b1);
   endtask

   // runtime reset closes the valves but keeps the pumps and circulation cycle
   task automatic test_runtime_reset();
      write_register(REG_TANK0, tank_word(1'b1, 8'd255, 8'd0, 8'd0, 8'd0));
      write_register(REG_TANK1, tank_word(1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      write_register(REG_CIRC, 33'h10000);
      tick(1'b1);
      tick(1'b1);
      send_request(CMD_RESET_RUN, 1'b0);
      tick(1'b0);
   endtask

   // a tank disabled while watering closes its valve and freezes its phase
   task automatic test_disable_while_watering();
      write_register(REG_TANK0, tank_word(1'b1, 8'd255, 8'd0, 8'd255, 8'd0));
      write_register(REG_TANK1, '0);
      tick(1'b1);
      write_register(REG_TANK0, tank_word(1'b0, 8'd255, 8'd0, 8'd255, 8'd0));
      tick(1'b1);
      tick(1'b0);
      write_register(REG_TANK0, tank_word(1'b1, 8'd255, 8'd0, 8'd255, 8'd0));
      tick(1'b1);
   endtask

   // zero preflush seconds: skipped on entry, cut short when changed mid-flush
   task automatic test_preflush_zero_seconds();
      write_register(REG_TANK0, tank_word(1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      write_register(REG_PREFLUSH, 33'h101);
      tick(1'b1);
      tick(1'b1);
      write_register(REG_PREFLUSH, 33'h100);
      tick(1'b1);
      tick(1'b0);
      tick(1'b0);
   endtask

   // batch: empty shared pause, hand-over between tanks, disabled mid-turn
   task automatic test_batch_sequencing();
      write_register(REG_TANK0, '0);
      write_register(REG_BATCH, 33'd1);
      tick(1'b1);
      write_register(REG_TANK1, tank_word(1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      write_register(REG_TANK2, tank_word(1'b1, 8'd255, 8'd0, 8'd255, 8'd0));
      tick(1'b1);
      tick(1'b0);
      write_register(REG_TANK2, tank_word(1'b0, 8'd255, 8'd0, 8'd255, 8'd0));
      tick(1'b1);
      write_register(REG_TANK2, '0);
      tick(1'b1);
   endtask

   // switching mode keeps phases and timers, then every register at its top
   task automatic test_mode_switch();
      tick(1'b1);
      write_register(REG_BATCH, '0);
      tick(1'b0);
      write_register(REG_TANK0, {CSR_DATA_W{1'b1}});
      write_register(REG_TANK1, {CSR_DATA_W{1'b1}});
      write_register(REG_TANK2, {CSR_DATA_W{1'b1}});
      write_register(REG_PREFLUSH, 33'h1FF);
      write_register(REG_BATCH, 33'd1);
      write_register(REG_CIRC, 33'h1FFFF);
      tick(1'b1);
   endtask

   // random settings between runs of ticks, occasional runtime resets
   task automatic test_random_sequencing();
      int   sent;
      int   len;
      logic light;
      sent = 0;
      while (sent < RANDOM_REQS) begin
         randomise_settings();
         wait_drained();
         // some runs go without any idling at all
         idling_on = ($urandom_range(0, 5) != 0);
         // a few long runs let one-second timers expire
         len   = ($urandom_range(0, 19) == 0) ? $urandom_range(1000, 1100)
                                              : $urandom_range(10, 80);
         light = 1'($urandom_range(0, 1));
         for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 15) == 0) light = ~light;
            if ($urandom_range(0, 39) == 0) send_request(CMD_RESET_RUN, light);
            else tick(light);
            sent++;
         end
      end
      idling_on = 1'b1;
   endtask

   // receiver holds off long enough for the block to back up its input
   task automatic test_response_backpressure();
      write_register(REG_BATCH, '0);
      write_register(REG_TANK0, tank_word(1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      write_register(REG_TANK1, tank_word(1'b1, 8'd0, 8'd0, 8'd0, 8'd0));
      write_register(REG_CIRC, 33'h10000);
      wait_drained();
      rsp_hold_cycles = 200;
      for (int n = 0; n < 40; n++) tick(1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // sender stops until everything owed has come back, then carries on
   task automatic test_sender_pause();
      for (int n = 0; n < 20; n++) tick(1'($urandom_range(0, 1)));
      wait_drained();
      for (int n = 0; n < 20; n++) tick(1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------

   // ready with random stalls, plus the long hold-off counted here
   initial begin : response_ready
      int stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) stall = pick_gap();
         end
      end
   end

   // compare every accepted response with the oldest owed drive word
   always @(posedge clock) begin : response_check
      drive_word_type seen;
      drive_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.valves           = rsp_if.tank_valves;
         seen.return_valve     = rsp_if.return_valve;
         seen.feed_pump        = rsp_if.feed_pump;
         seen.circulation_pump = rsp_if.circulation_pump;
         seen.phases           = rsp_if.tank_phases;
         if (expected_drives.size() == 0) begin
            if (fault_count < 10)
               $display("cycle %0d: response with nothing owed: %s",
                        cycle_count, drive_text(seen));
            fault_count++;
         end else begin
            want = expected_drives.pop_front();
            if (seen.valves !== want.valves ||
                seen.return_valve !== want.return_valve ||
                seen.feed_pump !== want.feed_pump ||
                seen.circulation_pump !== want.circulation_pump ||
                seen.phases !== want.phases) begin
               if (fault_count < 10)
                  $display("cycle %0d: mismatch, expected %s, got %s",
                           cycle_count, drive_text(want), drive_text(seen));
               fault_count++;
            end
         end
      end
   end

   // watchdog
   initial begin : cycle_watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("irrigation_valve_sequencer verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin : test_sequence
      fault_count     = 0;
      idling_on       = 1'b1;
      rsp_hold_cycles = 0;
      clear_sequencer();
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.command  <= CMD_TICK;
      req_if.light_on <= 1'b0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= REG_TANK0;
      csr_if.data     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_runtime_reset();
      test_disable_while_watering();
      test_preflush_zero_seconds();
      test_batch_sequencing();
      test_mode_switch();
      test_random_sequencing();
      test_response_backpressure();
      test_sender_pause();

      // let anything stray show up before judging
      wait_drained();
      repeat (LATENCY * 4) @(posedge clock);
      fault_count += expected_drives.size();

      if (fault_count == 0)
         $display("irrigation_valve_sequencer verification clean");
      else
         $display("irrigation_valve_sequencer verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ivs_pkg.sv
rtl/ivs_if.sv
rtl/ivs_step.sv
rtl/irrigation_valve_sequencer.sv
tb/irrigation_valve_sequencer_test.sv
